>>> hdl/upd_pkg.sv
// Shared types, constants and helper functions for the URL percent decoder.
// Used by every module of the decoder; depends on nothing else.

package upd_pkg;

  // Fixed field widths.
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 13;

  // Default saturation limit for the decoded length.
  localparam int MAX_LENGTH_DEF = 4096;

  // Decoded bytes produced by one input word, at most.
  localparam int GRP_SLOTS = 3;
  localparam int GRP_N_W   = 2;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int QCOUNT_W = 3;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_QUERY_MODE = 1'b0;  // register index, taken from paddr[2]

  // Character codes.
  localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [BYTE_W-1:0] CH_SUBST   = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_CTRL_LIM = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DEL     = 8'h7F;

  // Escape tracking state of the front.
  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_t;

  // Result of classifying a byte as a hex digit.
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Group of decoded bytes caused by one input word.
  typedef struct packed {
    logic [GRP_SLOTS-1:0][BYTE_W-1:0] bytes;
    logic [GRP_N_W-1:0]               n;
    logic                             last;
  } grp_t;

  // Classify one character as a hex digit of either case.
  function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
    hex_t h;
    h = '0;
    if (c inside {[8'h30:8'h39]}) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h57);
    end
    return h;
  endfunction

  // Append one byte to a group.
  function automatic grp_t grp_push(input grp_t g, input logic [BYTE_W-1:0] b);
    grp_t r;
    r = g;
    if (r.n < GRP_N_W'(GRP_SLOTS)) begin
      r.bytes[r.n] = b;
      r.n          = r.n + GRP_N_W'(1);
    end
    return r;
  endfunction

endpackage

>>> hdl/upd_front.sv
// Front of the decoder: accepts encoded words, tracks the escape state and
// builds the group of decoded bytes for each word. Depends on upd_pkg.

module upd_front import upd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              query_mode,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_last,
  input  logic              q_not_full,
  output logic              q_push,
  output grp_t              q_data
);

  esc_t              stage_r, stage_nxt;
  logic [3:0]        fd_r, fd_nxt;
  logic [BYTE_W-1:0] fdc_r, fdc_nxt;
  logic              accept;

  assign in_ready = q_not_full;
  assign accept   = in_valid && in_ready;

  // Escape state register; the held digit needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ESC_NONE;
    end else if (accept) begin
      stage_r <= stage_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fd_r  <= fd_nxt;
      fdc_r <= fdc_nxt;
    end
  end

  // Next escape state and the decoded bytes of this word.
  always_comb begin
    hex_t              hx;
    grp_t              g;
    logic              do_plain;
    logic [BYTE_W-1:0] dec;
    hx        = hex_decode(in_byte);
    g         = '0;
    g.last    = in_last;
    do_plain  = 1'b0;
    stage_nxt = stage_r;
    fd_nxt    = fd_r;
    fdc_nxt   = fdc_r;
    dec       = {fd_r, hx.val};
    if (dec < CH_CTRL_LIM || dec == CH_DEL) begin
      dec = CH_SUBST;
    end

    case (stage_r)
      ESC_PCT: begin
        if (hx.ok) begin
          fd_nxt    = hx.val;
          fdc_nxt   = in_byte;
          stage_nxt = ESC_DIGIT;
        end else begin
          g        = grp_push(g, CH_PERCENT);
          do_plain = 1'b1;
        end
      end
      ESC_DIGIT: begin
        stage_nxt = ESC_NONE;
        if (hx.ok) begin
          g = grp_push(g, dec);
        end else begin
          g        = grp_push(g, CH_PERCENT);
          g        = grp_push(g, fdc_r);
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    // Ordinary byte handling, also after a broken escape.
    if (do_plain) begin
      if (query_mode && in_byte == CH_PLUS) begin
        g         = grp_push(g, CH_SPACE);
        stage_nxt = ESC_NONE;
      end else if (in_byte == CH_PERCENT) begin
        stage_nxt = ESC_PCT;
      end else begin
        g         = grp_push(g, in_byte);
        stage_nxt = ESC_NONE;
      end
    end

    // The end of a string flushes a pending escape as plain text.
    if (in_last) begin
      if (stage_nxt == ESC_PCT) begin
        g = grp_push(g, CH_PERCENT);
      end else if (stage_nxt == ESC_DIGIT) begin
        g = grp_push(g, CH_PERCENT);
        g = grp_push(g, fdc_nxt);
      end
      stage_nxt = ESC_NONE;
    end

    q_data = g;
  end

  // Words that decode to nothing leave no entry in the queue.
  assign q_push = accept && (q_data.n != '0);

endmodule

>>> hdl/upd_queue.sv
// Short queue of decoded byte groups between the front and the back.
// Depends on upd_pkg.

module upd_queue import upd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t push_data,
  input  logic pop,
  output grp_t head,
  output logic not_empty,
  output logic not_full
);

  grp_t                mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCOUNT_W-1:0] count_r;
  logic                do_push, do_pop;

  assign not_empty = (count_r != '0);
  assign not_full  = (count_r != QCOUNT_W'(QDEPTH));
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCOUNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCOUNT_W'(1);
      end
    end
  end

endmodule

>>> hdl/upd_back.sv
// Back of the decoder: sends the bytes of each queued group one word per cycle
// while out_ready allows, keeps the saturating decoded length. Depends on upd_pkg.

module upd_back import upd_pkg::*; #(
  parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  grp_t              head,
  input  logic              q_not_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last,
  output logic [LEN_W-1:0]  out_decoded_length
);

  localparam int CNT_W = $clog2(MAX_LENGTH + 1);
  localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  logic [GRP_N_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, cnt_inc;
  logic [EXT_W-1:0]   cnt_ext;
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_last_r;
  logic [LEN_W-1:0]   out_len_r;
  logic               load, is_end;

  // The output register takes a new word when it is empty or being drained.
  assign load    = q_not_empty && (!out_valid_r || out_ready);
  assign is_end  = (k_r == head.n - GRP_N_W'(1));
  assign q_pop   = load && is_end;
  assign cnt_inc = (cnt_r == CNT_W'(MAX_LENGTH)) ? cnt_r : cnt_r + CNT_W'(1);
  assign cnt_ext = EXT_W'(cnt_inc);

  // Slot index, length count and output valid.
  always_comb begin
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      k_nxt         = is_end ? '0 : k_r + GRP_N_W'(1);
      cnt_nxt       = (head.last && is_end) ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= head.bytes[k_r];
      out_last_r <= head.last && is_end;
      out_len_r  <= cnt_ext[LEN_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_last           = out_last_r;
  assign out_decoded_length = out_len_r;

endmodule

>>> hdl/url_percent_decoder_top.sv
// Top level of the URL percent decoder: configuration register, front,
// group queue and back. Depends on upd_pkg, upd_front, upd_queue, upd_back.
//
//   Channel   Direction  Handshake              Word
//   input     in         in_valid / in_ready    in_byte, in_last
//   result    out        out_valid / out_ready  out_byte, out_last, out_decoded_length
//   config    in         psel/penable/pwrite    paddr, pwdata (prdata on reads)
//
// One input word is accepted per cycle while the four-entry group queue has
// room; out_valid for a word's first result rises once its group has passed
// the group queue and the output register. The back sends one decoded byte per
// cycle while out_ready is high, so words of two or three bytes fill the queue.
// Reset (rst_n low at a clock edge) empties the queue, clears the escape
// state, the length count and query_mode; no clearing pass is needed.
// Either side may stall freely; the queue and output register absorb it.

module url_percent_decoder_top import upd_pkg::*; #(
  parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BYTE_W-1:0]  in_byte,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_last,
  output logic [LEN_W-1:0]   out_decoded_length,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic query_mode_r;
  logic q_push, q_pop, q_not_empty, q_not_full;
  grp_t q_in, q_head;

  // Configuration register; word index comes from paddr[2].
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_mode_r <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_QUERY_MODE) begin
      query_mode_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_QUERY_MODE) ? PDATA_W'(query_mode_r) : '0;

  // Front: escape tracking and byte grouping.
  upd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .query_mode (query_mode_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .q_not_full (q_not_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  // Queue between front and back.
  upd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .not_full  (q_not_full)
  );

  // Back: serialization and length count.
  upd_back #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (q_head),
    .q_not_empty        (q_not_empty),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_last           (out_last),
    .out_decoded_length (out_decoded_length)
  );

endmodule

>>> hdl/upd_checker.sv
// Port-level checks for the URL percent decoder, bound to the top level.
// Depends on upd_pkg and url_percent_decoder_top.

module upd_checker import upd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [BYTE_W-1:0]  out_byte,
  input logic               out_last,
  input logic [LEN_W-1:0]   out_decoded_length,
  input logic [PDATA_W-1:0] prdata,
  input logic               pready
);

  // Leaving reset, the queue is empty and the output register holds nothing.
  a_reset_clean: assert property (@(posedge clk)
    $past(!rst_n) |-> (in_ready && !out_valid))
    else $error("decoder not clean after reset");

  // A stalled result word keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_byte) && $stable(out_last) &&
       $stable(out_decoded_length)))
    else $error("stalled result word changed");

  // Every result counts itself, so a shown length is never zero.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_decoded_length != '0))
    else $error("result word with zero length");

  // The configuration port never inserts wait states, and reads a single bit.
  a_cfg_port: assert property (@(posedge clk)
    pready && (prdata[PDATA_W-1:1] == '0))
    else $error("configuration port misbehaves");

endmodule

bind url_percent_decoder_top upd_checker u_upd_checker (.*);
